// File: src/depth_map_bilinear_sampler_core_defines.svh
// Assertion macros for the port-level checker.
`ifndef DEPTH_MAP_BILINEAR_SAMPLER_CORE_DEFINES_SVH
`define DEPTH_MAP_BILINEAR_SAMPLER_CORE_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define DMBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("check failed: label");
// Next-cycle implication checked outside reset.
`define DMBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("check failed: label");
`endif

// File: src/dmbs_pkg.sv
// Shared types, constants and codes of the depth-map sampler.
`default_nettype none
package dmbs_pkg;
	localparam int MaxWidth = 256;
	localparam int MaxHeight = 256;
	localparam int FracBits = 16;
	localparam int CoordFrac = 16;
	localparam int XW = $clog2(MaxWidth);
	localparam int YW = $clog2(MaxHeight);
	localparam int AW = XW + YW;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_DEPTH = 2'd1;
	localparam logic [1:0] OP_GRAD = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic REG_WIDTH = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] pixel_x;
		logic [7:0] pixel_y;
		logic signed [31:0] depth_in;
		logic [16:0] coord_x;
		logic [16:0] coord_y;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] depth_out;
		logic signed [31:0] grad_x;
		logic signed [31:0] grad_y;
		logic is_gradient;
	} out_item_t;

	// Datapath operations issued by the controller.
	typedef enum logic [2:0] {
		DP_NOP,
		DP_SPLIT,
		DP_READ,
		DP_GRAD,
		DP_BLEND
	} dp_op_t;

	// Command bundle from controller to datapath.
	typedef struct packed {
		dp_op_t op;
		logic [1:0] corner;
		logic [1:0] tap;
		logic [1:0] blend_step;
		logic sel_y;
	} dp_cmd_t;
endpackage
`default_nettype wire

// File: src/depth_map_bilinear_sampler_core.sv
// A sample item is taken only while the controller is idle, so a new item waits until the
// last result has moved to the output register, which waits on out_ready; every memory read
// uses the single read port, one per cycle (four for depth, sixteen for gradient), plus
// blend steps. Write items and unused codes are taken without leaving the idle state.
// Reset (arst_n low) clears the controller, output valid and the size registers
// (both 256); the depth memory has no reset and holds garbage until written.
`default_nettype none
module depth_map_bilinear_sampler_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire dmbs_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output dmbs_pkg::out_item_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [0:0] cfg_index,
	input wire logic [8:0] cfg_data
);
	dmbs_pkg::dp_cmd_t cmd;
	dmbs_pkg::out_item_t result;
	logic busy, load_out, in_fire, cfg_fire, out_free;
	logic cfg_valid_idx;

	assign in_ready = !busy;
	assign in_fire = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid;
	assign cfg_valid_idx = cfg_index[0];
	assign out_free = !out_valid || out_ready;

	dmbs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_op(in_data.operation),
		.out_free(out_free), .cmd(cmd), .busy(busy), .load_out(load_out)
	);

	dmbs_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_item(in_data),
		.cfg_fire(cfg_fire), .cfg_index(cfg_valid_idx), .cfg_data(cfg_data),
		.cmd(cmd), .result(result)
	);

	// Output register holds a finished item until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) out_data <= result;
	end
endmodule
`default_nettype wire

// File: src/dmbs_ctrl.sv
// Controller: sequences memory reads and blends for one item at a time.
`default_nettype none
module dmbs_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	input wire logic [1:0] in_op,
	input wire logic out_free,
	output dmbs_pkg::dp_cmd_t cmd,
	output logic busy,
	output logic load_out
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_SPLIT,
		S_READ,
		S_WAIT,
		S_BLEND,
		S_DONE
	} state_t;

	state_t state_q;
	logic grad_q;
	logic [1:0] corner_q;
	logic [1:0] tap_q;
	logic [1:0] step_q;
	logic sel_q;

	// Tap count per corner: depth reads one, gradient four.
	always_comb begin
		cmd = '0;
		cmd.corner = corner_q;
		cmd.tap = tap_q;
		cmd.blend_step = step_q;
		cmd.sel_y = sel_q;
		unique case (state_q)
			S_SPLIT: cmd.op = dmbs_pkg::DP_SPLIT;
			S_READ: cmd.op = dmbs_pkg::DP_READ;
			S_WAIT: cmd.op = dmbs_pkg::DP_GRAD;
			S_BLEND: cmd.op = dmbs_pkg::DP_BLEND;
			default: cmd.op = dmbs_pkg::DP_NOP;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign load_out = (state_q == S_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			grad_q <= 1'b0;
			corner_q <= '0;
			tap_q <= '0;
			step_q <= '0;
			sel_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire && (in_op == dmbs_pkg::OP_DEPTH ||
							in_op == dmbs_pkg::OP_GRAD)) begin
						state_q <= S_SPLIT;
						grad_q <= (in_op == dmbs_pkg::OP_GRAD);
					end
				end
				S_SPLIT: begin
					state_q <= S_READ;
					corner_q <= '0;
					tap_q <= '0;
				end
				S_READ: begin
					// Issue one read per cycle; its data is registered and arrives in the next cycle.
					if (!grad_q || tap_q == 2'd3) begin
						state_q <= S_WAIT;
					end else begin
						tap_q <= tap_q + 2'd1;
					end
				end
				S_WAIT: begin
					tap_q <= '0;
					if (corner_q == 2'd3) begin
						state_q <= S_BLEND;
						step_q <= '0;
						sel_q <= 1'b0;
					end else begin
						corner_q <= corner_q + 2'd1;
						state_q <= S_READ;
					end
				end
				S_BLEND: begin
					// Three blends for x result, three for y result when gradient.
					if (step_q == 2'd2) begin
						step_q <= '0;
						if (grad_q && !sel_q) begin
							sel_q <= 1'b1;
						end else begin
							state_q <= S_DONE;
						end
					end else begin
						step_q <= step_q + 2'd1;
					end
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: src/dmbs_datapath.sv
// Datapath: depth memory, coordinate split, gradient taps and shared blend unit.
`default_nettype none
module dmbs_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	input wire dmbs_pkg::in_item_t in_item,
	input wire logic cfg_fire,
	input wire logic cfg_index,
	input wire logic [8:0] cfg_data,
	input wire dmbs_pkg::dp_cmd_t cmd,
	output dmbs_pkg::out_item_t result
);
	localparam int XW = dmbs_pkg::XW;
	localparam int YW = dmbs_pkg::YW;

	logic [31:0] mem [dmbs_pkg::MaxWidth * dmbs_pkg::MaxHeight];
	logic [31:0] rd_q;
	logic [dmbs_pkg::AW-1:0] rd_addr;
	logic rd_take_q;
	logic [1:0] rd_tap_q;

	logic [8:0] width_q, height_q;
	logic [8:0] w_eff, h_eff;
	logic is_grad_q;
	logic [16:0] cx_q, cy_q;
	logic [XW-1:0] x0_q, x1_q;
	logic [YW-1:0] y0_q, y1_q;
	logic [dmbs_pkg::FracBits-1:0] tx_q, ty_q;
	logic signed [31:0] tap_q [4];
	logic signed [31:0] cg_x_q [4];
	logic signed [31:0] cg_y_q [4];
	logic signed [31:0] h0_q, h1_q;
	logic signed [31:0] res_x_q, res_y_q;

	// Effective sizes after range clamping.
	always_comb begin
		w_eff = (width_q == '0) ? 9'd1 :
			(width_q > 9'(dmbs_pkg::MaxWidth)) ? 9'(dmbs_pkg::MaxWidth) : width_q;
		h_eff = (height_q == '0) ? 9'd1 :
			(height_q > 9'(dmbs_pkg::MaxHeight)) ? 9'(dmbs_pkg::MaxHeight) : height_q;
	end

	// Coordinate split: saturate, scale by size-1, take integer and fraction.
	logic [16:0] cxs, cys;
	logic [25:0] px, py;
	logic [8:0] wm1, hm1;
	logic [XW-1:0] xi;
	logic [YW-1:0] yi;
	always_comb begin
		cxs = (cx_q > 17'h10000) ? 17'h10000 : cx_q;
		cys = (cy_q > 17'h10000) ? 17'h10000 : cy_q;
		wm1 = w_eff - 9'd1;
		hm1 = h_eff - 9'd1;
		px = 26'(cxs) * 26'(wm1);
		py = 26'(cys) * 26'(hm1);
		xi = px[dmbs_pkg::CoordFrac +: XW];
		yi = py[dmbs_pkg::CoordFrac +: YW];
	end

	// Corner and tap to pixel address.
	logic [XW-1:0] cxp, xl, xr, ax;
	logic [YW-1:0] cyp, yu, yd, ay;
	always_comb begin
		cxp = (cmd.corner == 2'd1 || cmd.corner == 2'd2) ? x1_q : x0_q;
		cyp = (cmd.corner == 2'd2 || cmd.corner == 2'd3) ? y1_q : y0_q;
		xl = (cxp != '0) ? cxp - XW'(1) : cxp;
		xr = (9'(cxp) < w_eff - 9'd1) ? cxp + XW'(1) : cxp;
		yu = (cyp != '0) ? cyp - YW'(1) : cyp;
		yd = (9'(cyp) < h_eff - 9'd1) ? cyp + YW'(1) : cyp;
		ax = cxp;
		ay = cyp;
		if (is_grad_q) begin
			case (cmd.tap)
				2'd0: ax = xr;
				2'd1: ax = xl;
				2'd2: ay = yd;
				default: ay = yu;
			endcase
		end
		rd_addr = {ay, ax};
	end

	// Shared blend unit: a + floor((b-a)*t / 2^FracBits).
	logic signed [31:0] ba, bb;
	logic [dmbs_pkg::FracBits-1:0] bt;
	logic signed [32:0] diff;
	logic signed [33+dmbs_pkg::FracBits:0] prod;
	logic signed [31:0] bres;
	always_comb begin
		case (cmd.blend_step)
			2'd0: begin
				ba = cmd.sel_y ? cg_y_q[0] : cg_x_q[0];
				bb = cmd.sel_y ? cg_y_q[1] : cg_x_q[1];
				bt = tx_q;
			end
			2'd1: begin
				ba = cmd.sel_y ? cg_y_q[3] : cg_x_q[3];
				bb = cmd.sel_y ? cg_y_q[2] : cg_x_q[2];
				bt = tx_q;
			end
			default: begin
				ba = h0_q;
				bb = h1_q;
				bt = ty_q;
			end
		endcase
		diff = 33'(bb) - 33'(ba);
		prod = (34 + dmbs_pkg::FracBits)'(diff) *
			$signed({1'b0, bt});
		bres = ba + 32'(prod >>> dmbs_pkg::FracBits);
	end

	// Memory write and registered read.
	always_ff @(posedge clk) begin
		if (in_fire && in_item.operation == dmbs_pkg::OP_WRITE) begin
			mem[{in_item.pixel_y[YW-1:0], in_item.pixel_x[XW-1:0]}] <= in_item.depth_in;
		end
		rd_q <= mem[rd_addr];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd256;
			height_q <= 9'd256;
			rd_take_q <= 1'b0;
		end else begin
			if (cfg_fire) begin
				if (cfg_index == dmbs_pkg::REG_WIDTH) width_q <= cfg_data;
				else height_q <= cfg_data;
			end
			rd_take_q <= (cmd.op == dmbs_pkg::DP_READ);
		end
	end

	// Working registers of one item.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cx_q <= in_item.coord_x;
			cy_q <= in_item.coord_y;
			is_grad_q <= (in_item.operation == dmbs_pkg::OP_GRAD);
		end
		rd_tap_q <= cmd.tap;
		if (cmd.op == dmbs_pkg::DP_SPLIT) begin
			x0_q <= xi;
			y0_q <= yi;
			x1_q <= (9'(xi) + 9'd1 < wm1) ? xi + XW'(1) : XW'(wm1);
			y1_q <= (9'(yi) + 9'd1 < hm1) ? yi + YW'(1) : YW'(hm1);
			tx_q <= px[dmbs_pkg::CoordFrac-1:0];
			ty_q <= py[dmbs_pkg::CoordFrac-1:0];
		end
		if (rd_take_q) tap_q[rd_tap_q] <= $signed(rd_q);
		// The last tap of a corner is still in the read register here.
		if (cmd.op == dmbs_pkg::DP_GRAD) begin
			if (is_grad_q) begin
				cg_x_q[cmd.corner] <= 32'((33'(tap_q[0]) - 33'(tap_q[1])) >>> 1);
				cg_y_q[cmd.corner] <= 32'((33'(tap_q[2]) - 33'($signed(rd_q))) >>> 1);
			end else begin
				cg_x_q[cmd.corner] <= $signed(rd_q);
			end
		end
		if (cmd.op == dmbs_pkg::DP_BLEND) begin
			case (cmd.blend_step)
				2'd0: h0_q <= bres;
				2'd1: h1_q <= bres;
				default: begin
					if (cmd.sel_y) res_y_q <= bres;
					else res_x_q <= bres;
				end
			endcase
		end
	end

	always_comb begin
		result.is_gradient = is_grad_q;
		result.depth_out = is_grad_q ? 32'sd0 : res_x_q;
		result.grad_x = is_grad_q ? res_x_q : 32'sd0;
		result.grad_y = is_grad_q ? res_y_q : 32'sd0;
	end
endmodule
`default_nettype wire

// File: src/dmbs_checker.sv
// Port-level checker for the sampler, bound to the top level.
`default_nettype none
`include "depth_map_bilinear_sampler_core_defines.svh"
module dmbs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire dmbs_pkg::out_item_t out_data
);
	`DMBS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`DMBS_ASSERT_NEXT(a_sample_busy, clk, arst_n, in_valid && in_ready && !out_valid, !out_valid)
	`DMBS_ASSERT_IMP(a_grad_zero, clk, arst_n, out_valid && out_data.is_gradient, out_data.depth_out == 32'sd0)
	`DMBS_ASSERT_IMP(a_depth_zero, clk, arst_n, out_valid && !out_data.is_gradient, out_data.grad_x == 32'sd0 && out_data.grad_y == 32'sd0)
endmodule

bind depth_map_bilinear_sampler_core dmbs_checker u_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
